FILE: hdl/bive_pkg.sv
// Shared types and constants for the bounded integer vector engine.
package bive_pkg;

  localparam int CAPACITY  = 256;
  localparam int WORD_BITS = 32;
  localparam int ADDR_BITS = $clog2(CAPACITY);
  localparam int CNT_BITS  = ADDR_BITS + 1;

  localparam logic [2:0] ACT_PUSH  = 3'd0;
  localparam logic [2:0] ACT_POP   = 3'd1;
  localparam logic [2:0] ACT_READ  = 3'd2;
  localparam logic [2:0] ACT_WRITE = 3'd3;
  localparam logic [2:0] ACT_ERASE = 3'd4;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_BAD   = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_EMPTY = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SHIFT,
    ST_FIN
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic commit;
    logic shift_init;
    logic shift_step;
    logic erase_commit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic erase_ok;
    logic shift_done;
  } dp_stat_t;

endpackage

FILE: hdl/bive_ctrl.sv
// Controller state machine for the bounded integer vector engine.
module bive_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bive_pkg::dp_stat_t stat_i,
  output bive_pkg::dp_cmd_t  cmd_o
);
  import bive_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat_i.erase_ok) begin
          cmd_o.shift_init = 1'b1;
          state_d          = ST_SHIFT;
        end else if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_SHIFT: begin
        if (stat_i.shift_done) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.shift_step = 1'b1;
        end
      end
      ST_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.erase_commit = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/bive_dpath.sv
// Datapath of the bounded integer vector engine: element memory, count, result register.
module bive_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bive_pkg::dp_cmd_t               cmd_i,
  output bive_pkg::dp_stat_t              stat_o,
  input  logic [2:0]                      action_i,
  input  logic signed [31:0]              value_i,
  input  logic [7:0]                      index_i,
  input  logic [7:0]                      last_index_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [31:0]              data_out_o,
  output logic [8:0]                      size_after_o,
  output logic [1:0]                      status_o
);
  import bive_pkg::*;

  logic [WORD_BITS-1:0] mem [CAPACITY];

  logic [2:0]           act_q;
  logic [WORD_BITS-1:0] val_q;
  logic [ADDR_BITS-1:0] idx_q, last_q;
  logic [WORD_BITS-1:0] rdata_q;
  logic [CNT_BITS-1:0]  count_q, count_d;
  logic [CNT_BITS-1:0]  src_q, src_d;
  logic [ADDR_BITS-1:0] dst_q, dst_d;
  logic                 pend_q, pend_d;

  logic                 out_valid_q;
  logic [WORD_BITS-1:0] data_q, data_d;
  logic [CNT_BITS-1:0]  size_q;
  logic [1:0]           status_q, status_d;

  logic                 rd_en;
  logic [ADDR_BITS-1:0] rd_addr;
  logic                 wr_en;
  logic [ADDR_BITS-1:0] wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic [CNT_BITS-1:0]  idx_ext, last_ext, erase_num;
  logic                 read_more;

  assign idx_ext   = {1'b0, idx_q};
  assign last_ext  = {1'b0, last_q};
  assign erase_num = last_ext - idx_ext + CNT_BITS'(1);
  assign read_more = src_q < count_q;

  assign stat_o.out_free   = !out_valid_q || !out_stall_i;
  assign stat_o.erase_ok   = (act_q == ACT_ERASE) && (idx_q <= last_q) && (last_ext < count_q);
  assign stat_o.shift_done = !read_more && !pend_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      act_q  <= action_i;
      val_q  <= WORD_BITS'(value_i);
      idx_q  <= index_i;
      last_q <= last_index_i;
    end
  end

  // Read port: item fetch on accept, source fetch during the shift.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = index_i;
    if (cmd_i.accept) begin
      rd_en = 1'b1;
      if (action_i == ACT_POP) begin
        rd_addr = count_q[ADDR_BITS-1:0] - ADDR_BITS'(1);
      end
    end else if (cmd_i.shift_step && read_more) begin
      rd_en   = 1'b1;
      rd_addr = src_q[ADDR_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Single-action evaluation, erase shift pointers and write port.
  always_comb begin
    count_d  = count_q;
    data_d   = '0;
    status_d = STAT_OK;
    wr_en    = 1'b0;
    wr_addr  = dst_q;
    wr_data  = rdata_q;
    src_d    = src_q;
    dst_d    = dst_q;
    pend_d   = pend_q;
    case (act_q)
      ACT_PUSH: begin
        if (count_q >= CNT_BITS'(CAPACITY)) begin
          status_d = STAT_FULL;
        end else begin
          if (cmd_i.commit) begin
            wr_en   = 1'b1;
            wr_addr = count_q[ADDR_BITS-1:0];
            wr_data = val_q;
          end
          count_d = count_q + CNT_BITS'(1);
        end
      end
      ACT_POP: begin
        if (count_q == '0) begin
          status_d = STAT_EMPTY;
        end else begin
          count_d = count_q - CNT_BITS'(1);
          data_d  = rdata_q;
        end
      end
      ACT_READ: begin
        if (idx_ext >= count_q) begin
          status_d = STAT_BAD;
        end else begin
          data_d = rdata_q;
        end
      end
      ACT_WRITE: begin
        if (idx_ext >= count_q) begin
          status_d = STAT_BAD;
        end else if (cmd_i.commit) begin
          wr_en   = 1'b1;
          wr_addr = idx_q;
          wr_data = val_q;
        end
      end
      ACT_ERASE: begin
        if (!stat_o.erase_ok) begin
          status_d = STAT_BAD;
        end else begin
          count_d = count_q - erase_num;
        end
      end
      default: begin
        status_d = STAT_BAD;
      end
    endcase
    if (cmd_i.shift_init) begin
      src_d  = last_ext + CNT_BITS'(1);
      dst_d  = idx_q;
      pend_d = 1'b0;
    end else if (cmd_i.shift_step) begin
      pend_d = read_more;
      if (read_more) begin
        src_d = src_q + CNT_BITS'(1);
      end
      if (pend_q) begin
        wr_en   = 1'b1;
        wr_addr = dst_q;
        wr_data = rdata_q;
        dst_d   = dst_q + ADDR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    src_q <= src_d;
    dst_q <= dst_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (cmd_i.commit || cmd_i.erase_commit) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit || cmd_i.erase_commit) begin
      data_q   <= data_d;
      size_q   <= count_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign data_out_o   = signed'(data_q);
  assign size_after_o = size_q;
  assign status_o     = status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_BITS'(CAPACITY))
    else $error("element count above capacity");

  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.accept, cmd_i.commit, cmd_i.shift_init, cmd_i.shift_step,
              cmd_i.erase_commit}))
    else $error("more than one datapath command");

  a_shift_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift_step |-> ({1'b0, dst_q} < src_q))
    else $error("shift destination not below source");

  a_erase_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.erase_commit |-> (erase_num <= count_q))
    else $error("erase removes more than stored");

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit || cmd_i.erase_commit) |-> stat_o.out_free)
    else $error("result loaded while output held");

endmodule

FILE: hdl/bounded_int_vector_engine_core.sv
// Top level of the bounded integer vector engine: controller plus datapath.
// Push, pop, read, write, failed erase: accepted in ST_IDLE, result registered when
//   ST_EXEC commits once the output is free; no new transaction is taken before that.
// Erase of range [f, l]: ST_EXEC checks the range, ST_SHIFT moves the words above l down
//   to f, one word per cycle, and ST_FIN registers the result once the output is free.
// Reset (asynchronous, active low) empties the store and clears the output valid flag; the
//   element memory and the output data are not cleared and no clearing pass runs.
module bounded_int_vector_engine_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         action_i,
  input  logic signed [31:0] value_i,
  input  logic [7:0]         index_i,
  input  logic [7:0]         last_index_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] data_out_o,
  output logic [8:0]         size_after_o,
  output logic [1:0]         status_o
);
  import bive_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bive_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bive_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .action_i     (action_i),
    .value_i      (value_i),
    .index_i      (index_i),
    .last_index_i (last_index_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .data_out_o   (data_out_o),
    .size_after_o (size_after_o),
    .status_o     (status_o)
  );

endmodule
